// ----- rtl/sacl_pkg.sv -----
// Package for the set-associative cache LRU tracker.
// Holds sizes, command codes and the controller/datapath command and status structs.
package sacl_pkg;
  localparam int MAX_SET_BITS = 10;
  localparam int MAX_WAYS = 8;
  localparam int SET_COUNT = 1 << MAX_SET_BITS;
  localparam int WAY_W = $clog2(MAX_WAYS);
  localparam int RANK_W = (WAY_W < 1) ? 1 : WAY_W;
  localparam int TAG_W = 62;
  localparam int ADDR_W = 64;
  localparam int CNT_W = 32;
  localparam int WCNT_W = $clog2(MAX_WAYS + 1);

  localparam logic [1:0] CMD_IFETCH = 2'd0;
  localparam logic [1:0] CMD_MODIFY = 2'd3;

  localparam logic [1:0] REG_SET_BITS = 2'd0;
  localparam logic [1:0] REG_OFF_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS = 2'd2;

  typedef struct packed {
    logic load;      // capture item, clear per-item flags
    logic rd;        // read set
    logic wr;        // resolve access and write back
  } dp_cmd_t;

  typedef struct packed {
    logic clearing;  // valid bits still being cleared after reset
    logic skip;      // command is instruction fetch
    logic twice;     // command is modify
  } dp_sts_t;
endpackage

// ----- rtl/sacl_ctrl.sv -----
// Controller state machine for the cache LRU tracker.
// Uses sacl_pkg; sequences load, read and write steps for one or two accesses, or none for a fetch.
module sacl_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output sacl_pkg::dp_cmd_t cmd,
  input  sacl_pkg::dp_sts_t sts
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_WR   = 5'b00100,
    S_RD2  = 5'b01000,
    S_WR2  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic out_full, out_full_next;
  logic done;

  assign in_stall = (state != S_IDLE) || sts.clearing || (out_full && out_stall);
  assign out_valid = out_full;

  always_comb begin
    state_next = state;
    done = 1'b0;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.load = 1'b1;
          state_next = S_RD;
        end
      end
      S_RD: begin
        if (sts.skip) begin
          done = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.rd = 1'b1;
          state_next = S_WR;
        end
      end
      S_WR: begin
        cmd.wr = 1'b1;
        if (sts.twice) state_next = S_RD2;
        else begin
          done = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RD2: begin
        cmd.rd = 1'b1;
        state_next = S_WR2;
      end
      S_WR2: begin
        cmd.wr = 1'b1;
        done = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_full_next = out_full;
    if (out_full && !out_stall) out_full_next = 1'b0;
    if (done) out_full_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      out_full <= out_full_next;
    end
  end
endmodule

// ----- rtl/sacl_dp.sv -----
// Datapath for the cache LRU tracker: line store, LRU update, totals, result fields.
// Uses sacl_pkg; driven by sacl_ctrl. Valid bits cleared by a pass after reset.
module sacl_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [5:0]                  cfg_data,
  input  logic [1:0]                  command,
  input  logic [sacl_pkg::ADDR_W-1:0] address,
  input  sacl_pkg::dp_cmd_t           cmd,
  output sacl_pkg::dp_sts_t           sts,
  output logic [1:0]                  hits_now,
  output logic                        missed,
  output logic                        evicted,
  output logic [sacl_pkg::CNT_W-1:0]  total_hits,
  output logic [sacl_pkg::CNT_W-1:0]  total_misses,
  output logic [sacl_pkg::CNT_W-1:0]  total_evictions
);
  localparam int W = sacl_pkg::MAX_WAYS;
  localparam int RW = sacl_pkg::RANK_W;
  localparam int TW = sacl_pkg::TAG_W;
  localparam int SB = sacl_pkg::MAX_SET_BITS;
  localparam logic [RW-1:0] RANK_TOP = RW'(W - 1);

  logic [3:0] set_bits_r;
  logic [5:0] off_bits_r;
  logic [3:0] ways_r;

  logic [3:0] s_eff;
  logic [5:0] b_eff;
  logic [sacl_pkg::WCNT_W-1:0] ways;

  logic [1:0] cmd_q;
  logic [sacl_pkg::ADDR_W-1:0] addr_q;
  logic [TW-1:0] tag_q;
  logic [SB-1:0] set_q;

  logic clearing;
  logic [SB-1:0] clr_idx;

  logic [W-1:0] valid_mem [sacl_pkg::SET_COUNT];
  logic [W-1:0][TW-1:0] tag_mem [sacl_pkg::SET_COUNT];
  logic [W-1:0][RW-1:0] rank_mem [sacl_pkg::SET_COUNT];

  logic [W-1:0] rd_valid;
  logic [W-1:0][TW-1:0] rd_tag;
  logic [W-1:0][RW-1:0] rd_rank;

  logic [W-1:0] in_use, match;
  logic hit;
  logic [sacl_pkg::WAY_W-1:0] hit_way, empty_way, lru_way, victim;
  logic found_empty;
  logic [RW-1:0] best, limit;
  logic [W-1:0] new_valid;
  logic [W-1:0][RW-1:0] new_rank;

  logic [1:0] hits_cnt;
  logic miss_f, ev_f;
  logic [sacl_pkg::CNT_W-1:0] hit_tot, miss_tot, ev_tot;

  assign s_eff = (set_bits_r == 4'd0) ? 4'd1 :
                 (set_bits_r > 4'(SB)) ? 4'(SB) : set_bits_r;
  assign b_eff = (off_bits_r == 6'd0) ? 6'd1 : (off_bits_r > 6'd32) ? 6'd32 : off_bits_r;
  assign ways = (ways_r == 4'd0) ? sacl_pkg::WCNT_W'(1) :
                (ways_r > 4'(W)) ? sacl_pkg::WCNT_W'(W) : sacl_pkg::WCNT_W'(ways_r);

  assign sts.skip = (cmd_q == sacl_pkg::CMD_IFETCH);
  assign sts.twice = (cmd_q == sacl_pkg::CMD_MODIFY);
  assign sts.clearing = clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits_r <= 4'd1;
      off_bits_r <= 6'd1;
      ways_r <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        sacl_pkg::REG_SET_BITS: set_bits_r <= cfg_data[3:0];
        sacl_pkg::REG_OFF_BITS: off_bits_r <= cfg_data;
        sacl_pkg::REG_WAYS:     ways_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q <= command;
      addr_q <= address;
    end
  end

  // address split from the captured item
  assign tag_q = TW'(addr_q >> (s_eff + b_eff));
  assign set_q = SB'((addr_q >> b_eff) & ((64'd1 << s_eff) - 64'd1));

  // one set of valid bits cleared per cycle after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + SB'(1);
      if (clr_idx == '1) clearing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_tag <= tag_mem[set_q];
      rd_rank <= rank_mem[set_q];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) rd_valid <= '0;
    else if (cmd.rd) rd_valid <= valid_mem[set_q];
  end

  always_comb begin
    hit = 1'b0;
    hit_way = '0;
    found_empty = 1'b0;
    empty_way = '0;
    lru_way = '0;
    best = '0;
    for (int w = W - 1; w >= 0; w--) begin
      in_use[w] = (w < int'(ways));
      match[w] = in_use[w] && rd_valid[w] && (rd_tag[w] == tag_q);
      if (match[w]) begin
        hit = 1'b1;
        hit_way = sacl_pkg::WAY_W'(w);
      end
      if (in_use[w] && !rd_valid[w]) begin
        found_empty = 1'b1;
        empty_way = sacl_pkg::WAY_W'(w);
      end
    end
    for (int w = 0; w < W; w++) begin
      if (in_use[w] && (w == 0 || rd_rank[w] > best)) begin
        best = rd_rank[w];
        lru_way = sacl_pkg::WAY_W'(w);
      end
    end
    if (hit) limit = rd_rank[hit_way];
    else if (found_empty) limit = RANK_TOP;
    else limit = best;
    victim = hit ? hit_way : (found_empty ? empty_way : lru_way);
    new_valid = rd_valid;
    new_valid[victim] = 1'b1;
    for (int w = 0; w < W; w++) begin
      new_rank[w] = rd_rank[w];
      if (in_use[w] && rd_valid[w] && rd_rank[w] < limit && rd_rank[w] < RANK_TOP)
        new_rank[w] = rd_rank[w] + RW'(1);
      if (found_empty && !hit && in_use[w] && rd_valid[w] && rd_rank[w] < RANK_TOP)
        new_rank[w] = rd_rank[w] + RW'(1);
    end
    new_rank[victim] = '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      tag_mem[set_q][victim] <= tag_q;
      rank_mem[set_q] <= new_rank;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) valid_mem[clr_idx] <= '0;
    else if (cmd.wr) valid_mem[set_q] <= new_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_tot <= '0;
      miss_tot <= '0;
      ev_tot <= '0;
    end else if (cmd.wr) begin
      if (hit && hit_tot != '1) hit_tot <= hit_tot + 1'b1;
      if (!hit && miss_tot != '1) miss_tot <= miss_tot + 1'b1;
      if (!hit && !found_empty && ev_tot != '1) ev_tot <= ev_tot + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hits_cnt <= '0;
      miss_f <= 1'b0;
      ev_f <= 1'b0;
    end else if (cmd.wr) begin
      if (hit) hits_cnt <= hits_cnt + 2'd1;
      if (!hit && hits_cnt == 2'd0 && !ev_f && !miss_f) miss_f <= 1'b1;
      if (!hit && !found_empty) ev_f <= 1'b1;
    end
  end

  // result fields come straight from the item flags and totals, which hold
  // until the next item is loaded
  assign hits_now = hits_cnt;
  assign missed = miss_f;
  assign evicted = ev_f;
  assign total_hits = hit_tot;
  assign total_misses = miss_tot;
  assign total_evictions = ev_tot;
endmodule

// ----- rtl/set_assoc_cache_lru_tracker.sv -----
// Top level of the set-associative cache LRU tracker.
// Uses sacl_pkg, sacl_ctrl and sacl_dp.
//
//  channel  signals                               direction
//  in       in_valid/in_stall, command, address   into block
//  out      out_valid/out_stall, hits_now..totals out of block
//  cfg      cfg_we, cfg_index, cfg_data           into block
//
// An item is accepted, then fetch ends with no access, load/store makes one access
// and modify makes two; each access is one set read and one write back. The result is
// valid from the next cycle, and a new item can be accepted in that same cycle
// unless out_stall is high. After reset the valid bits are cleared one set per cycle
// with the input stalled; totals and config registers are set by reset itself.
// The result holds while out_stall is high; input stalls while busy or blocked.
module set_assoc_cache_lru_tracker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [63:0] address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  hits_now,
  output logic        missed,
  output logic        evicted,
  output logic [31:0] total_hits,
  output logic [31:0] total_misses,
  output logic [31:0] total_evictions
);
  sacl_pkg::dp_cmd_t cmd;
  sacl_pkg::dp_sts_t sts;

  sacl_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .sts
  );

  sacl_dp u_dp (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .command, .address, .cmd, .sts,
    .hits_now, .missed, .evicted,
    .total_hits, .total_misses, .total_evictions
  );

  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (cmd.rd || cmd.wr) |-> in_stall) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(total_hits))
    else $error("result changed under stall");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.rd, cmd.wr})) else $error("overlapping commands");
endmodule
